### hw/rtl/cnoms_pkg.sv
// ----------------------------------------------------------------------------
// cnoms_pkg
// shared types and constants of the carrier-to-noise mode check
// ----------------------------------------------------------------------------
package cnoms_pkg;

    localparam int CNO_W   = 11;
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 13;
    localparam int LVL_W   = 2;
    localparam int CFG_W   = 11;
    localparam int CFG_A_W = 2;
    // near-mode band half-width in 1/16 dB-Hz
    localparam logic [CNO_W:0] NEAR_BAND = 12'd16;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_INCONS_THRESH = 2'd1,
        CFG_UNASSR_THRESH = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [LVL_W-1:0] {
        LVL_ASSURED      = 2'd0,
        LVL_INCONSISTENT = 2'd1,
        LVL_UNASSURED    = 2'd2,
        LVL_RESERVED     = 2'd3
    } level_t;

    typedef struct packed {
        logic [CNO_W-1:0] cno_value;
        logic             epoch_end;
    } in_word_t;

    typedef struct packed {
        logic [LVL_W-1:0] assurance_level;
        logic [SUM_W-1:0] window_sum;
        logic [CNT_W-1:0] near_mode_count;
        logic [CNO_W-1:0] mode_value;
    } out_word_t;

    // front to back: one epoch summary
    typedef struct packed {
        logic             has_mode;
        logic [CNO_W-1:0] mode_value;
        logic [CNT_W-1:0] near_count;
    } epoch_sum_t;

    typedef enum logic [2:0] {
        FS_COLLECT,
        FS_OUTER,
        FS_PRIOR,
        FS_COUNT,
        FS_NEAR,
        FS_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_WRITE,
        BS_MUL,
        BS_CMP,
        BS_READ,
        BS_DROP,
        BS_EMIT
    } back_state_t;

endpackage

### hw/rtl/cnoms_front.sv
// ----------------------------------------------------------------------------
// cnoms_front
// collects one epoch, searches the mode and counts near-mode entries
// ----------------------------------------------------------------------------
module cnoms_front #(
    parameter int MAX_SATS = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  cnoms_pkg::in_word_t     in_word,
    output logic                    sum_valid,
    input  logic                    sum_ready,
    output cnoms_pkg::epoch_sum_t   sum_word
);
    import cnoms_pkg::*;

    localparam int IW = (MAX_SATS > 1) ? $clog2(MAX_SATS) : 1;
    localparam int FW = $clog2(MAX_SATS + 1);

    front_state_t      state_reg, state_next;
    logic [FW-1:0]     fill_reg;
    logic [IW-1:0]     i_reg, j_reg;
    logic [CNO_W-1:0]  cand_reg, best_val_reg;
    logic [FW-1:0]     cnt_reg, best_cnt_reg;
    logic [CNT_W-1:0]  near_reg;
    logic [CNO_W-1:0]  mem [MAX_SATS];
    logic [CNO_W-1:0]  rd_reg;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic              phase_reg;

    wire [FW-1:0] i_ext = FW'(i_reg);
    wire [FW-1:0] j_ext = FW'(j_reg);
    wire          j_last = (j_ext + 1'b1) >= fill_reg;
    wire          i_last = (i_ext + 1'b1) >= fill_reg;

    assign wr_en = (state_reg == FS_COLLECT) && in_valid && (fill_reg < FW'(MAX_SATS));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[fill_reg[IW-1:0]] <= in_word.cno_value;
        end
        rd_reg <= mem[rd_addr];
    end

    // candidate fetch reads at i, every other scan at j
    always_comb begin
        rd_addr = (state_reg == FS_OUTER) ? i_reg : j_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FS_COLLECT: if (in_valid && in_word.epoch_end) state_next = FS_OUTER;
            FS_OUTER: begin
                if (phase_reg) begin
                    if (rd_reg == '0) begin
                        if (i_last) state_next = FS_NEAR;
                    end else if (i_reg == '0) begin
                        state_next = FS_COUNT;
                    end else begin
                        state_next = FS_PRIOR;
                    end
                end
            end
            FS_PRIOR: begin
                if (phase_reg) begin
                    if (rd_reg == cand_reg) begin
                        state_next = i_last ? FS_NEAR : FS_OUTER;
                    end else if (j_ext + 1'b1 >= i_ext) begin
                        state_next = FS_COUNT;
                    end
                end
            end
            FS_COUNT: begin
                if (phase_reg && j_last) state_next = i_last ? FS_NEAR : FS_OUTER;
            end
            FS_NEAR: begin
                if (best_cnt_reg == '0) state_next = FS_PUSH;
                else if (phase_reg && j_last) state_next = FS_PUSH;
            end
            FS_PUSH:    if (sum_ready) state_next = FS_COLLECT;
            default:    state_next = FS_COLLECT;
        endcase
    end

    assign in_ready  = (state_reg == FS_COLLECT);
    assign sum_valid = (state_reg == FS_PUSH);
    always_comb begin
        sum_word.has_mode   = (best_cnt_reg != '0);
        sum_word.mode_value = best_val_reg;
        sum_word.near_count = near_reg;
    end

    // scan sequencer: phase_reg waits for the registered read of the addressed entry into rd_reg
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_COLLECT;
            fill_reg  <= '0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                FS_COLLECT: begin
                    if (in_valid) begin
                        if (wr_en) fill_reg <= fill_reg + 1'b1;
                    end
                    i_reg        <= '0;
                    j_reg        <= '0;
                    best_cnt_reg <= '0;
                    best_val_reg <= '0;
                    near_reg     <= '0;
                    phase_reg    <= 1'b0;
                end
                FS_OUTER: begin
                    // fetch candidate i
                    if (!phase_reg) begin
                        j_reg     <= i_reg;
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        cand_reg  <= rd_reg;
                        cnt_reg   <= '0;
                        if (rd_reg == '0) begin
                            if (i_last) j_reg <= '0;
                            else        i_reg <= i_reg + 1'b1;
                        end else if (i_reg != '0) begin
                            j_reg <= '0;
                        end
                    end
                end
                FS_PRIOR: begin
                    // was the candidate seen earlier
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        if (rd_reg == cand_reg) begin
                            if (i_last) j_reg <= '0;
                            else        i_reg <= i_reg + 1'b1;
                        end else if (j_ext + 1'b1 >= i_ext) begin
                            j_reg <= i_reg;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                FS_COUNT: begin
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg <= 1'b0;
                        if (j_last) begin
                            if ((cnt_reg + FW'(rd_reg == cand_reg)) > best_cnt_reg) begin
                                best_cnt_reg <= cnt_reg + FW'(rd_reg == cand_reg);
                                best_val_reg <= cand_reg;
                            end
                            if (i_last) j_reg <= '0;
                            else        i_reg <= i_reg + 1'b1;
                        end else begin
                            cnt_reg <= cnt_reg + FW'(rd_reg == cand_reg);
                            j_reg   <= j_reg + 1'b1;
                        end
                    end
                end
                FS_NEAR: begin
                    if (best_cnt_reg != '0) begin
                        if (!phase_reg) begin
                            phase_reg <= 1'b1;
                        end else begin
                            phase_reg <= 1'b0;
                            if (({1'b0, rd_reg} + NEAR_BAND > {1'b0, best_val_reg}) &&
                                ({1'b0, rd_reg} < {1'b0, best_val_reg} + NEAR_BAND)) begin
                                near_reg <= near_reg + 1'b1;
                            end
                            if (!j_last) j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                FS_PUSH: begin
                    if (sum_ready) begin
                        fill_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(MAX_SATS)) else $error("epoch fill overflow");
    a_push_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_valid && sum_ready) |=> (fill_reg == '0)) else $error("fill not cleared");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != FS_COLLECT) |-> !in_ready) else $error("ready while scanning");
`endif

endmodule

### hw/rtl/cnoms_queue.sv
// ----------------------------------------------------------------------------
// cnoms_queue
// two-entry queue between epoch summarizer and history unit
// ----------------------------------------------------------------------------
module cnoms_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  cnoms_pkg::epoch_sum_t wr_word,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output cnoms_pkg::epoch_sum_t rd_word
);
    import cnoms_pkg::*;

    epoch_sum_t slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    wire do_wr = wr_valid && wr_ready;
    wire do_rd = rd_valid && rd_ready;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_word  = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) slot_reg[wp_reg] <= wr_word;
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

`ifndef ASSERT_OFF
    a_count_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> (wp_reg != rp_reg)) else $error("queue pointers");
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue count");
    a_ptr_eq: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd1) |-> (wp_reg == rp_reg)) else $error("queue pointers");
`endif

endmodule

### hw/rtl/cnoms_back.sv
// ----------------------------------------------------------------------------
// cnoms_back
// history window of near-mode counts and the assurance decision
// ----------------------------------------------------------------------------
module cnoms_back #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [6:0]              window_length,
    input  logic [10:0]             incons_thresh,
    input  logic [10:0]             unassr_thresh,
    input  logic                    sum_valid,
    output logic                    sum_ready,
    input  cnoms_pkg::epoch_sum_t   sum_word,
    output logic                    out_valid,
    input  logic                    out_ready,
    output cnoms_pkg::out_word_t    out_word
);
    import cnoms_pkg::*;

    localparam int HW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int HFW = $clog2(MAX_WINDOW + 1);
    localparam int PW  = CFG_W + HFW;
    localparam int SW  = SUM_W + 4;
    localparam int MW  = (PW > SW) ? PW : SW;

    back_state_t      state_reg, state_next;
    logic [CNT_W-1:0] hist [MAX_WINDOW];
    logic [CNT_W-1:0] rd_reg;
    logic [HW-1:0]    oldest_reg;
    logic [HFW-1:0]   fill_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [PW-1:0]    pu_reg, pi_reg;
    epoch_sum_t       cur_reg;
    out_word_t        res_reg;
    logic [HFW-1:0]   win;

    always_comb begin
        if (window_length == '0) win = HFW'(1);
        else if (int'(window_length) > MAX_WINDOW) win = HFW'(MAX_WINDOW);
        else win = HFW'(window_length);
    end

    // ring position of the next free slot
    wire [HFW:0]  wsum = (HFW+1)'(oldest_reg) + (HFW+1)'(fill_reg);
    wire [HW-1:0] wpos = (wsum >= (HFW+1)'(MAX_WINDOW)) ?
                         HW'(wsum - (HFW+1)'(MAX_WINDOW)) : HW'(wsum);
    wire          do_push = cur_reg.has_mode && (fill_reg < HFW'(MAX_WINDOW));
    wire [MW-1:0] s16 = MW'({sum_reg, 4'b0000});

    assign sum_ready = (state_reg == BS_IDLE);
    assign out_valid = (state_reg == BS_EMIT);
    assign out_word  = res_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == BS_WRITE && do_push) hist[wpos] <= cur_reg.near_count;
        rd_reg <= hist[oldest_reg];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:  if (sum_valid) state_next = BS_WRITE;
            BS_WRITE: state_next = BS_MUL;
            BS_MUL: begin
                if (fill_reg < win || fill_reg == '0) state_next = BS_IDLE;
                else state_next = BS_CMP;
            end
            BS_CMP:   state_next = BS_READ;
            BS_READ:  state_next = BS_DROP;
            BS_DROP:  state_next = BS_EMIT;
            BS_EMIT:  if (out_ready) state_next = BS_IDLE;
            default:  state_next = BS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BS_IDLE;
            oldest_reg <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                BS_IDLE: if (sum_valid) begin
                    cur_reg <= sum_word;
                end
                BS_WRITE: begin
                    if (do_push) begin
                        fill_reg <= fill_reg + 1'b1;
                        sum_reg  <= sum_reg + SUM_W'(cur_reg.near_count);
                    end
                end
                BS_MUL: begin
                    pu_reg <= PW'(unassr_thresh) * PW'(fill_reg);
                    pi_reg <= PW'(incons_thresh) * PW'(fill_reg);
                end
                BS_CMP: begin
                    priority if (s16 >= MW'(pu_reg))
                        res_reg.assurance_level <= LVL_UNASSURED;
                    else if (s16 >= MW'(pi_reg))
                        res_reg.assurance_level <= LVL_INCONSISTENT;
                    else
                        res_reg.assurance_level <= LVL_ASSURED;
                    res_reg.window_sum      <= sum_reg;
                    res_reg.near_mode_count <= cur_reg.has_mode ? cur_reg.near_count : '0;
                    res_reg.mode_value      <= cur_reg.has_mode ? cur_reg.mode_value : '0;
                end
                BS_DROP: begin
                    sum_reg    <= sum_reg - SUM_W'(rd_reg);
                    oldest_reg <= (oldest_reg == HW'(MAX_WINDOW - 1)) ? '0 : oldest_reg + 1'b1;
                    fill_reg   <= fill_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= HFW'(MAX_WINDOW)) else $error("history overflow");
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BS_CMP) |-> (fill_reg != '0)) else $error("decision on empty history");
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BS_DROP) |=> (fill_reg == $past(fill_reg) - 1'b1))
        else $error("drop count");
`endif

endmodule

### hw/rtl/cno_mode_spoof_check.sv
// ----------------------------------------------------------------------------
// cno_mode_spoof_check
// carrier-to-noise mode check used as a spoofing indicator
// ----------------------------------------------------------------------------
// throughput: one word per cycle inside an epoch; the closing word starts
//   a serial mode search over the epoch memory, and no new word is taken
//   until the summary is pushed on to the queue and history unit
// reset: aresetn synchronous active low; registers take 10, 64, 112,
//   epoch and history empty, no clearing pass
module cno_mode_spoof_check #(
    parameter int MAX_SATS   = 64,
    parameter int MAX_WINDOW = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [10:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cnoms_pkg::in_word_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cnoms_pkg::out_word_t  m_data
);
    import cnoms_pkg::*;

    // configuration registers
    logic [6:0]  win_len_reg;
    logic [10:0] incons_reg, unassr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= 7'd10;
            incons_reg  <= 11'd64;
            unassr_reg  <= 11'd112;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW_LENGTH: win_len_reg <= cfg_data[6:0];
                CFG_INCONS_THRESH: incons_reg  <= cfg_data;
                CFG_UNASSR_THRESH: unassr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: epoch capture and mode search
    logic       f_valid, f_ready, q_valid, q_ready;
    epoch_sum_t f_word, q_word;

    cnoms_front #(.MAX_SATS(MAX_SATS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_word(s_data),
        .sum_valid(f_valid), .sum_ready(f_ready), .sum_word(f_word)
    );

    // short queue decouples the search from the history unit
    cnoms_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_word(f_word),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_word(q_word)
    );

    // back: history window and decision
    cnoms_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
        .aclk, .aresetn,
        .window_length(win_len_reg), .incons_thresh(incons_reg),
        .unassr_thresh(unassr_reg),
        .sum_valid(q_valid), .sum_ready(q_ready), .sum_word(q_word),
        .out_valid(m_valid), .out_ready(m_ready), .out_word(m_data)
    );

`ifndef ASSERT_OFF
    a_cfg_rst: assert property (@(posedge aclk)
        !aresetn |=> (win_len_reg == 7'd10)) else $error("config reset");
    a_lvl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.assurance_level != LVL_RESERVED)) else $error("bad level");
    a_mode_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.mode_value == '0) |-> (m_data.near_mode_count == '0))
        else $error("count without mode");
`endif

endmodule
